### src/matrix_multiply_engine_unit_assert.svh
// assertion macros for the matrix multiply engine checker
`ifndef MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define MME_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MME_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mme_pkg.sv
// shared types and constants of the matrix multiply engine
package mme_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } mme_op_t;

    typedef enum logic [1:0] {
        REG_ROWS_A = 2'd0,
        REG_COLS_A = 2'd1,
        REG_ROWS_B = 2'd2,
        REG_COLS_B = 2'd3
    } mme_reg_t;

    localparam int DIM_BITS   = 4;
    localparam int IDX_BITS   = 3;
    localparam int VAL_BITS   = 16;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;
    localparam int OP_BITS    = 2;
    localparam int FRAC_BITS  = 8;

endpackage

### src/matrix_multiply_engine_unit.sv
// matrix multiply engine top level: element stores, shared mac and sequencer
//
//  channel   ports                      contents
//  input     s_tvalid/s_tready          tuser opcode, tdata row, col, value
//  result    m_tvalid/m_tready          tdata row, col, value, clipped
//                                       tuser dim_error, tlast end of run
//  config    cfg_we/cfg_index/cfg_data  rows_a, cols_a, rows_b, cols_b
//
// a compute is paced by the single multiplier and accumulator, which step read,
// multiply and add for every inner term of every result element, then wait for
// room in the output register; s_tready stays low from a compute transfer until
// the last result of the run or the mismatch result is loaded into that register
// reset clears the sequencer and output valid, sets the dimensions to one, not the stores
module matrix_multiply_engine_unit
    import mme_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // elem_row, elem_col, elem_value
    input  logic [OP_BITS-1:0]    s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // out_row, out_col, product_value, clipped
    output logic                  m_tuser,   // dim_error
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [DIM_BITS-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int PROD_W = 2 * ELEM_BITS;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - ELEM_BITS + 1){1'b0}}, {(ELEM_BITS - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN = ~SAT_MAX;
    // running sum is held within plus or minus 2^62, reachable only for wide elements
    localparam bit ACC_CLAMP = (ACC_W > 63);
    localparam logic signed [ACC_W-1:0] ACC_LIM   = ACC_W'(1) << 62;
    localparam logic signed [ACC_W-1:0] ACC_LIM_N = -ACC_LIM;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ERR  = 6'b000010,
        ST_RD   = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_OUT  = 6'b100000
    } mme_state_t;

    mme_state_t state_reg, state_next;

    logic [DIM_BITS-1:0] rows_a_reg, cols_a_reg, rows_b_reg, cols_b_reg;
    logic [IDX_W-1:0]    i_reg, j_reg, k_reg;
    logic [IDX_W-1:0]    last_i_reg, last_j_reg, last_k_reg;

    logic signed [ELEM_BITS-1:0] a_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] b_mem [DEPTH];
    logic signed [ELEM_BITS-1:0] a_q_reg, b_q_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;

    logic [IDX_BITS-1:0] out_row_reg, out_col_reg;
    logic [VAL_BITS-1:0] out_val_reg;
    logic                out_clip_reg, out_err_reg, out_last_reg, out_valid_reg;

    logic [IDX_BITS-1:0]  in_row, in_col;
    logic [ELEM_BITS-1:0] in_val;
    logic                 in_xfer, in_ok, out_free, elem_done, run_done;
    logic [AW-1:0]        wr_addr, a_addr, b_addr;
    logic signed [ACC_W-1:0] shifted, sat_val;
    logic signed [ACC_W-1:0] mac_sum, mac_clamped;
    logic                 sat_clip;

    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_BITS-1:0] d);
        logic [IDX_W-1:0] r;
        if (d == '0) begin
            r = '0;
        end else if (32'(d) > MAX_DIM) begin
            r = IDX_W'(MAX_DIM - 1);
        end else begin
            r = IDX_W'(32'(d) - 1);
        end
        return r;
    endfunction

    assign in_row  = s_tdata[2:0];
    assign in_col  = s_tdata[5:3];
    assign in_val  = ELEM_BITS'(s_tdata[21:6]);
    assign in_xfer = s_tvalid && s_tready;
    assign in_ok   = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
    assign wr_addr = AW'(32'(in_row) * MAX_DIM + 32'(in_col));
    assign a_addr  = AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign b_addr  = AW'(32'(k_reg) * MAX_DIM + 32'(j_reg));

    assign out_free  = !out_valid_reg || m_tready;
    assign elem_done = (k_reg == last_k_reg);
    assign run_done  = (i_reg == last_i_reg) && (j_reg == last_j_reg);

    always_comb begin
        mac_sum     = acc_reg + ACC_W'(prod_reg);
        mac_clamped = mac_sum;
        if (ACC_CLAMP) begin
            if (mac_sum > ACC_LIM) begin
                mac_clamped = ACC_LIM;
            end else if (mac_sum < ACC_LIM_N) begin
                mac_clamped = ACC_LIM_N;
            end
        end
    end

    assign shifted = acc_reg >>> FRAC_BITS;
    always_comb begin
        sat_val  = shifted;
        sat_clip = 1'b0;
        if (shifted > SAT_MAX) begin
            sat_val  = SAT_MAX;
            sat_clip = 1'b1;
        end else if (shifted < SAT_MIN) begin
            sat_val  = SAT_MIN;
            sat_clip = 1'b1;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_tuser == OP_COMPUTE) begin
                    state_next = (cols_a_reg != rows_b_reg) ? ST_ERR : ST_RD;
                end
            end
            ST_ERR:  if (out_free) state_next = ST_IDLE;
            ST_RD:   state_next = ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = elem_done ? ST_OUT : ST_RD;
            ST_OUT: begin
                if (out_free) begin
                    state_next = run_done ? ST_IDLE : ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rows_a_reg <= DIM_BITS'(1);
            cols_a_reg <= DIM_BITS'(1);
            rows_b_reg <= DIM_BITS'(1);
            cols_b_reg <= DIM_BITS'(1);
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (mme_reg_t'(cfg_index))
                    REG_ROWS_A: rows_a_reg <= cfg_data;
                    REG_COLS_A: cols_a_reg <= cfg_data;
                    REG_ROWS_B: rows_b_reg <= cfg_data;
                    REG_COLS_B: cols_b_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // element stores
    always_ff @(posedge aclk) begin
        if (in_xfer && in_ok) begin
            case (mme_op_t'(s_tuser))
                OP_WRITE_A: a_mem[wr_addr] <= in_val;
                OP_WRITE_B: b_mem[wr_addr] <= in_val;
                default: ;
            endcase
        end
        a_q_reg <= a_mem[a_addr];
        b_q_reg <= b_mem[b_addr];
    end

    // counters and shared mac
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                i_reg      <= '0;
                j_reg      <= '0;
                k_reg      <= '0;
                acc_reg    <= '0;
                last_i_reg <= last_index(rows_a_reg);
                last_j_reg <= last_index(cols_b_reg);
                last_k_reg <= last_index(cols_a_reg);
            end
            ST_MUL: prod_reg <= a_q_reg * b_q_reg;
            ST_ACC: begin
                acc_reg <= mac_clamped;
                if (!elem_done) begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    acc_reg <= '0;
                    k_reg   <= '0;
                    if (j_reg == last_j_reg) begin
                        j_reg <= '0;
                        i_reg <= i_reg + IDX_W'(1);
                    end else begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_ERR && out_free) begin
                out_valid_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
            end
        end
        if (state_reg == ST_ERR && out_free) begin
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_val_reg  <= '0;
            out_clip_reg <= 1'b0;
            out_err_reg  <= 1'b1;
            out_last_reg <= 1'b1;
        end
        if (state_reg == ST_OUT && out_free) begin
            out_row_reg  <= IDX_BITS'(i_reg);
            out_col_reg  <= IDX_BITS'(j_reg);
            out_val_reg  <= sat_val[VAL_BITS-1:0];
            out_clip_reg <= sat_clip;
            out_err_reg  <= 1'b0;
            out_last_reg <= run_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_clip_reg, out_val_reg, out_col_reg, out_row_reg};
    assign m_tuser  = out_err_reg;
    assign m_tlast  = out_last_reg;

endmodule

### src/mme_checker.sv
// port checker for the matrix multiply engine and its bind
`include "matrix_multiply_engine_unit_assert.svh"

module mme_checker
    import mme_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [OP_BITS-1:0]  s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic                m_tuser,
    input logic                m_tlast
);

    `MME_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `MME_ASSERT_IMP(a_busy_mid_run, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "input ready in the middle of a run")
    `MME_ASSERT_IMP(a_err_shape, aclk, aresetn, m_tvalid && m_tuser, m_tlast && (m_tdata == '0), "malformed mismatch result")
    `MME_ASSERT_NXT(a_compute_busy, aclk, aresetn, s_tvalid && s_tready && (s_tuser == OP_COMPUTE), !s_tready, "ready right after a compute transfer")

endmodule

bind matrix_multiply_engine_unit mme_checker u_mme_checker (.*);

### tb/sv/matrix_multiply_engine_unit_test.sv
// self-checking testbench for the matrix multiply engine: element loads, products, dimension errors
module matrix_multiply_engine_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mme_pkg::*;

    localparam int MAX_DIM = 8;
    localparam int RAND_ITEMS = 210;
    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
        logic [VAL_BITS-1:0] value;
        logic                clipped;
        logic                dim_error;
        logic                last;
    } prod_elem_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // elem_row, elem_col, elem_value
    logic [OP_BITS-1:0]  s_tuser;   // opcode
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // out_row, out_col, product_value, clipped
    logic                m_tuser;   // dim_error
    logic                m_tlast;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [DIM_BITS-1:0] cfg_data;

    logic signed [VAL_BITS-1:0] a_mem [MAX_DIM*MAX_DIM];
    logic signed [VAL_BITS-1:0] b_mem [MAX_DIM*MAX_DIM];
    bit                         a_set [MAX_DIM*MAX_DIM];
    bit                         b_set [MAX_DIM*MAX_DIM];
    logic [DIM_BITS-1:0]        dims [4];
    prod_elem_t                 product_q [$];

    int items_sent;
    int errors;
    bit src_no_idle;
    bit snk_no_stall;

    matrix_multiply_engine_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    task automatic report_error(string msg);
        $display("error at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int eff_dim(logic [DIM_BITS-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    function automatic logic [VAL_BITS-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // expected elements of C for the current stores and dimensions
    task automatic predict_product();
        int         nr;
        int         nk;
        int         nc;
        longint     acc;
        longint     q;
        prod_elem_t e;
        if (dims[REG_COLS_A] != dims[REG_ROWS_B]) begin
            e = '0;
            e.dim_error = 1'b1;
            e.last = 1'b1;
            product_q.push_back(e);
            return;
        end
        nr = eff_dim(dims[REG_ROWS_A]);
        nk = eff_dim(dims[REG_COLS_A]);
        nc = eff_dim(dims[REG_COLS_B]);
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = 0;
                for (int k = 0; k < nk; k++) begin
                    acc += longint'(a_mem[i*MAX_DIM+k]) * longint'(b_mem[k*MAX_DIM+j]);
                end
                q = acc >>> FRAC_BITS;
                e.clipped = 1'b0;
                if (q > 32767) begin
                    q = 32767;
                    e.clipped = 1'b1;
                end else if (q < -32768) begin
                    q = -32768;
                    e.clipped = 1'b1;
                end
                e.row = IDX_BITS'(i);
                e.col = IDX_BITS'(j);
                e.value = q[VAL_BITS-1:0];
                e.dim_error = 1'b0;
                e.last = (i == nr - 1) && (j == nc - 1);
                product_q.push_back(e);
            end
        end
    endtask

    task automatic send_item(logic [OP_BITS-1:0] op, int row, int col, logic [VAL_BITS-1:0] value);
        int gap;
        gap = src_no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {2'b00, value, 3'(col), 3'(row)};
        do @(posedge aclk); while (!s_tready);
        case (op)
            OP_WRITE_A: begin
                a_mem[row*MAX_DIM+col] = value;
                a_set[row*MAX_DIM+col] = 1'b1;
            end
            OP_WRITE_B: begin
                b_mem[row*MAX_DIM+col] = value;
                b_set[row*MAX_DIM+col] = 1'b1;
            end
            OP_COMPUTE: predict_product();
            default: ;
        endcase
        if (op != OP_UNUSED) items_sent++;
    endtask

    // hold the input side until every expected element is out, then let the engine settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (product_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_dims(int ra, int ca, int rb, int cb);
        int vals [4];
        vals = '{ra, ca, rb, cb};
        for (int r = 0; r < 4; r++) begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(r);
            cfg_data <= DIM_BITS'(vals[r]);
            @(posedge aclk);
            dims[r] = DIM_BITS'(vals[r]);
        end
        cfg_we <= 1'b0;
    endtask

    // load every element a product of these sizes reads that was never loaded
    task automatic make_ready(int nr, int nk, int nc);
        for (int i = 0; i < nr; i++) begin
            for (int k = 0; k < nk; k++) begin
                if (!a_set[i*MAX_DIM+k]) send_item(OP_WRITE_A, i, k, rand_value());
            end
        end
        for (int k = 0; k < nk; k++) begin
            for (int j = 0; j < nc; j++) begin
                if (!b_set[k*MAX_DIM+j]) send_item(OP_WRITE_B, k, j, rand_value());
            end
        end
    endtask

    task automatic test_saturation();
        drain_results();
        set_dims(1, 1, 1, 1);
        send_item(OP_WRITE_A, 0, 0, 16'h7fff);
        send_item(OP_WRITE_B, 0, 0, 16'h7fff);
        send_item(OP_COMPUTE, 0, 0, 16'h0000);
        send_item(OP_WRITE_B, 0, 0, 16'h8000);
        send_item(OP_COMPUTE, 7, 7, 16'hffff);
        send_item(OP_WRITE_A, 0, 0, 16'h8000);
        send_item(OP_COMPUTE, 0, 0, 16'h0000);
    endtask

    task automatic test_dim_mismatch();
        drain_results();
        set_dims(1, 3, 2, 1);
        send_item(OP_COMPUTE, 0, 0, 16'h0000);
        drain_results();
        // zero acts as one for sizes but the check compares raw values
        set_dims(1, 0, 1, 1);
        send_item(OP_COMPUTE, 0, 0, 16'h0000);
    endtask

    task automatic test_dim_clamp();
        drain_results();
        set_dims(15, 0, 0, 15);
        make_ready(MAX_DIM, 1, MAX_DIM);
        send_item(OP_UNUSED, 7, 7, 16'hffff);
        send_item(OP_COMPUTE, 0, 0, 16'h0000);
    endtask

    task automatic test_random_products();
        int start;
        int ra;
        int ca;
        int rb;
        int cb;
        int nr;
        int nk;
        int nc;
        start = items_sent;
        while (items_sent - start < RAND_ITEMS) begin
            drain_results();
            if ($urandom_range(0, 7) == 0) begin
                ra = $urandom_range(0, 15);
                ca = $urandom_range(0, 15);
                cb = $urandom_range(0, 15);
                rb = $urandom_range(0, 1) ? ca : $urandom_range(0, 15);
            end else begin
                ra = $urandom_range(1, 4);
                ca = $urandom_range(1, 4);
                cb = $urandom_range(1, 4);
                rb = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : ca;
            end
            set_dims(ra, ca, rb, cb);
            src_no_idle = ($urandom_range(0, 3) == 0);
            nr = eff_dim(DIM_BITS'(ra));
            nk = eff_dim(DIM_BITS'(ca));
            nc = eff_dim(DIM_BITS'(cb));
            repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(0, 7))
                    0: send_item(OP_UNUSED, $urandom_range(0, 7), $urandom_range(0, 7),
                                 16'($urandom));
                    1: send_item($urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A,
                                 $urandom_range(0, 7), $urandom_range(0, 7), rand_value());
                    default: begin
                        if ($urandom_range(0, 1))
                            send_item(OP_WRITE_A, $urandom_range(0, nr - 1),
                                      $urandom_range(0, nk - 1), rand_value());
                        else
                            send_item(OP_WRITE_B, $urandom_range(0, nk - 1),
                                      $urandom_range(0, nc - 1), rand_value());
                    end
                endcase
            end
            if (ca == rb) make_ready(nr, nk, nc);
            send_item(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
        end
        src_no_idle = 1'b0;
    endtask

    // result side: random stalls, one check per transfer
    initial begin
        prod_elem_t got;
        prod_elem_t want;
        int         stall;
        int         seen;
        seen = 0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (seen % 16 == 0) snk_no_stall = ($urandom_range(0, 3) == 0);
            stall = snk_no_stall ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            seen++;
            got.row = m_tdata[2:0];
            got.col = m_tdata[5:3];
            got.value = m_tdata[21:6];
            got.clipped = m_tdata[22];
            got.dim_error = m_tuser;
            got.last = m_tlast;
            if (product_q.size() == 0) begin
                report_error($sformatf("unexpected result row %0d col %0d value %0d",
                                       got.row, got.col, $signed(got.value)));
            end else begin
                want = product_q.pop_front();
                if (got.row !== want.row)
                    report_error($sformatf("out_row got %0d expected %0d", got.row, want.row));
                if (got.col !== want.col)
                    report_error($sformatf("out_col got %0d expected %0d", got.col, want.col));
                if (got.value !== want.value)
                    report_error($sformatf("product_value got %0d expected %0d",
                                           $signed(got.value), $signed(want.value)));
                if (got.clipped !== want.clipped)
                    report_error($sformatf("clipped got %b expected %b",
                                           got.clipped, want.clipped));
                if (got.dim_error !== want.dim_error)
                    report_error($sformatf("dim_error got %b expected %b",
                                           got.dim_error, want.dim_error));
                if (got.last !== want.last)
                    report_error($sformatf("last got %b expected %b", got.last, want.last));
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        items_sent = 0;
        errors = 0;
        src_no_idle = 1'b0;
        for (int r = 0; r < 4; r++) dims[r] = 1;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_saturation();
        test_dim_mismatch();
        test_dim_clamp();
        test_random_products();
        drain_results();
        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/mme_pkg.sv
src/matrix_multiply_engine_unit.sv
src/mme_checker.sv
tb/sv/matrix_multiply_engine_unit_test.sv
